// ----- src/dsrc_pkg.sv -----
`default_nettype none

package dsrc_pkg;

  localparam int SUM_DEPTH_DEF = 256;
  localparam int CNT_W         = 30;
  localparam int DIGIT_W       = 4;
  localparam int CFG_W         = 9;
  localparam int HIST_LEN      = 10;

  localparam logic [CNT_W-1:0]   MODULUS   = 30'd1000000007;
  localparam logic [DIGIT_W-1:0] TOP_DIGIT = 4'd9;
  localparam logic [CFG_W-1:0]   MIN_RESET = 9'd1;
  localparam logic [CFG_W-1:0]   MAX_RESET = 9'd400;

  typedef enum logic [0:0] {
    CFG_MIN_SUM,
    CFG_MAX_SUM
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_DRAIN,
    ST_TOTAL,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic start;
    logic issue;
    logic fresh;
    logic commit;
    logic clear;
  } lane_ctl_t;

  function automatic logic [CNT_W-1:0] add_mod(input logic [CNT_W-1:0] a,
                                               input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, MODULUS}) begin
      s = s - {1'b0, MODULUS};
    end
    return s[CNT_W-1:0];
  endfunction

  function automatic logic [CNT_W-1:0] sub_mod(input logic [CNT_W-1:0] a,
                                               input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    if (a >= b) begin
      s = {1'b0, a} - {1'b0, b};
    end else begin
      s = {1'b0, a} + {1'b0, MODULUS} - {1'b0, b};
    end
    return s[CNT_W-1:0];
  endfunction

  function automatic logic [DIGIT_W-1:0] clamp_digit(input logic [DIGIT_W-1:0] d);
    return (d > TOP_DIGIT) ? TOP_DIGIT : d;
  endfunction

endpackage

`default_nettype wire

// ----- src/dsrc_lane.sv -----
`default_nettype none

module dsrc_lane #(
  parameter int SUM_DEPTH = dsrc_pkg::SUM_DEPTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire dsrc_pkg::lane_ctl_t              ctl,
  input  wire logic [$clog2(SUM_DEPTH)-1:0]     addr,
  input  wire logic [dsrc_pkg::DIGIT_W-1:0]     digit,
  input  wire logic [dsrc_pkg::CFG_W-1:0]       min_sum,
  input  wire logic [dsrc_pkg::CFG_W-1:0]       max_sum,
  output logic      [dsrc_pkg::CNT_W-1:0]       acc,
  output logic                                  tight_hit,
  output logic                                  pending
);

  localparam int SW    = $clog2(SUM_DEPTH);
  localparam int TW    = $clog2(SUM_DEPTH + 1);
  localparam int CMP_W = (TW > dsrc_pkg::CFG_W) ? TW : dsrc_pkg::CFG_W;
  localparam int CW    = dsrc_pkg::CNT_W;
  localparam int HL    = dsrc_pkg::HIST_LEN;

  logic [CW-1:0] mem [SUM_DEPTH];
  logic [CW-1:0] rd_data;
  logic [CW-1:0] hist [HL];
  logic [CW-1:0] old_val;
  logic [CW-1:0] diff;
  logic [CW-1:0] win;
  logic [CW-1:0] wval;
  logic [SW-1:0] a1, a2, a3, a4;
  logic          v1, v2, v3, v4;
  logic [dsrc_pkg::DIGIT_W-1:0] d;
  logic [TW-1:0] tight;
  logic [TW:0]   tight_ext;
  logic [TW:0]   tight_end;
  logic [TW:0]   a3_ext;
  logic          ind;
  logic          a4_hit;

  // table read for the sweep, write-back of the updated entry
  always_ff @(posedge clk) begin
    if (ctl.issue) begin
      rd_data <= mem[addr];
    end
    if (v4) begin
      mem[a4] <= wval;
    end
  end

  assign old_val   = ctl.fresh ? '0 : rd_data;
  assign tight_ext = (TW+1)'(tight);
  assign tight_end = tight_ext + (TW+1)'(d);
  assign a3_ext    = (TW+1)'(a3);
  assign ind       = (tight_ext <= a3_ext) && (a3_ext < tight_end);
  assign a4_hit    = (CMP_W'(a4) >= CMP_W'(min_sum)) && (CMP_W'(a4) <= CMP_W'(max_sum));
  assign tight_hit = (CMP_W'(tight) >= CMP_W'(min_sum)) &&
                     (CMP_W'(tight) <= CMP_W'(max_sum)) &&
                     (tight <= TW'(SUM_DEPTH - 1));
  assign pending   = v1 | v2 | v3 | v4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      v2    <= 1'b0;
      v3    <= 1'b0;
      v4    <= 1'b0;
      tight <= '0;
    end else begin
      v1 <= ctl.issue;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      if (ctl.clear) begin
        tight <= '0;
      end else if (ctl.commit) begin
        tight <= (tight_end > (TW+1)'(SUM_DEPTH)) ? TW'(SUM_DEPTH) : tight_end[TW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    a1 <= addr;
    a2 <= a1;
    a3 <= a2;
    a4 <= a3;
    if (ctl.start) begin
      d   <= dsrc_pkg::clamp_digit(digit);
      win <= '0;
      acc <= '0;
      for (int i = 0; i < HL; i++) begin
        hist[i] <= '0;
      end
    end else begin
      // ten-wide window: add the entry coming in, drop the one ten back
      if (v1) begin
        diff    <= dsrc_pkg::sub_mod(old_val, hist[HL-1]);
        hist[0] <= old_val;
        for (int i = 1; i < HL; i++) begin
          hist[i] <= hist[i-1];
        end
      end
      if (v2) begin
        win <= dsrc_pkg::add_mod(win, diff);
      end
      if (v3) begin
        wval <= dsrc_pkg::add_mod(win, CW'(ind));
      end
      if (v4 && a4_hit) begin
        acc <= dsrc_pkg::add_mod(acc, wval);
      end
    end
  end

endmodule

`default_nettype wire

// ----- src/digit_sum_range_counter.sv -----
// digit_sum_range_counter
// Counts integers in [low, high] whose decimal digit sum lies in
// [min_digit_sum, max_digit_sum], modulo 1000000007.
// Input channel (in_valid / in_stall): one request per digit pair, most
// significant first, low bound zero-padded; last_digit marks the final pair.
// Output channel (out_valid / out_stall): one good_count per final pair.
// Config channel (cfg_valid / cfg_ready, always ready): cfg_index 0 writes
// min_digit_sum, 1 writes max_digit_sum; write only while idle.
// Each digit sweeps both count tables, one entry per cycle, each table through
// its own window adder pipeline; the final digit then passes a total state and
// an emit state before good_count is presented. in_stall is high throughout.
// A finished count sits in the output register while the next request is
// taken; if the receiver still stalls when a new count is ready, the block
// holds until the register frees.
// Reset (rst, synchronous) restores the window to 1..400 and starts a fresh
// pair of bounds; tables are treated as zero on the first sweep, no clearing
// pass is needed.
`default_nettype none

module digit_sum_range_counter #(
  parameter int SUM_DEPTH = dsrc_pkg::SUM_DEPTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [dsrc_pkg::DIGIT_W-1:0] low_digit,
  input  wire logic [dsrc_pkg::DIGIT_W-1:0] high_digit,
  input  wire logic                         last_digit,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic      [dsrc_pkg::CNT_W-1:0]   good_count,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [0:0]                   cfg_index,
  input  wire logic [dsrc_pkg::CFG_W-1:0]   cfg_data
);

  localparam int SW = $clog2(SUM_DEPTH);
  localparam int CW = dsrc_pkg::CNT_W;

  dsrc_pkg::state_t    state, state_next;
  dsrc_pkg::lane_ctl_t ctl;
  logic [SW-1:0]       cnt;
  logic                last_flag;
  logic                fresh;
  logic [dsrc_pkg::CFG_W-1:0] min_sum, max_sum;
  logic [CW-1:0]       total;
  logic [CW-1:0]       acc_h, acc_l;
  logic                hit_h, hit_l;
  logic                pend_h, pend_l;
  logic                accept;
  logic                out_free;
  logic                load_out;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != dsrc_pkg::ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_sum <= dsrc_pkg::MIN_RESET;
      max_sum <= dsrc_pkg::MAX_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        dsrc_pkg::CFG_MIN_SUM: min_sum <= cfg_data;
        dsrc_pkg::CFG_MAX_SUM: max_sum <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dsrc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    ctl.fresh  = fresh;
    load_out   = 1'b0;
    case (state)
      dsrc_pkg::ST_IDLE: begin
        if (accept) begin
          ctl.start  = 1'b1;
          state_next = dsrc_pkg::ST_SWEEP;
        end
      end
      dsrc_pkg::ST_SWEEP: begin
        ctl.issue = 1'b1;
        if (cnt == SW'(SUM_DEPTH - 1)) begin
          state_next = dsrc_pkg::ST_DRAIN;
        end
      end
      dsrc_pkg::ST_DRAIN: begin
        if (!pend_h && !pend_l) begin
          ctl.commit = 1'b1;
          state_next = last_flag ? dsrc_pkg::ST_TOTAL : dsrc_pkg::ST_IDLE;
        end
      end
      dsrc_pkg::ST_TOTAL: begin
        state_next = dsrc_pkg::ST_EMIT;
      end
      dsrc_pkg::ST_EMIT: begin
        if (out_free) begin
          load_out   = 1'b1;
          ctl.clear  = 1'b1;
          state_next = dsrc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = dsrc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      fresh     <= 1'b1;
      out_valid <= 1'b0;
      last_flag <= 1'b0;
    end else begin
      if (ctl.start) begin
        cnt       <= '0;
        last_flag <= last_digit;
      end else if (ctl.issue) begin
        cnt <= cnt + SW'(1);
      end
      if (ctl.clear) begin
        fresh <= 1'b1;
      end else if (ctl.commit) begin
        fresh <= 1'b0;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // high count includes its own tight path; low's tight path is not subtracted, so low itself is counted
  always_ff @(posedge clk) begin
    if (state == dsrc_pkg::ST_TOTAL) begin
      total <= dsrc_pkg::add_mod(acc_h, CW'(hit_h));
    end
    if (load_out) begin
      good_count <= dsrc_pkg::sub_mod(total, acc_l);
    end
  end

  dsrc_lane #(.SUM_DEPTH(SUM_DEPTH)) u_lane_high (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .addr      (cnt),
    .digit     (high_digit),
    .min_sum   (min_sum),
    .max_sum   (max_sum),
    .acc       (acc_h),
    .tight_hit (hit_h),
    .pending   (pend_h)
  );

  dsrc_lane #(.SUM_DEPTH(SUM_DEPTH)) u_lane_low (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .addr      (cnt),
    .digit     (low_digit),
    .min_sum   (min_sum),
    .max_sum   (max_sum),
    .acc       (acc_l),
    .tight_hit (hit_l),
    .pending   (pend_l)
  );

  a_out_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == dsrc_pkg::ST_EMIT))
    else $error("result raised outside emit");

  a_count_reduced: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (good_count < dsrc_pkg::MODULUS))
    else $error("good_count not reduced");

  a_idle_drained: assert property (@(posedge clk) disable iff (rst)
    (state == dsrc_pkg::ST_IDLE) |-> (!pend_h && !pend_l))
    else $error("lane pipeline busy while idle");

  a_sweep_from_zero: assert property (@(posedge clk) disable iff (rst)
    (state == dsrc_pkg::ST_SWEEP && $past(state == dsrc_pkg::ST_IDLE)) |-> (cnt == '0))
    else $error("sweep did not start at entry zero");

  a_low_bonus_used: assert property (@(posedge clk) disable iff (rst)
    (state == dsrc_pkg::ST_TOTAL) |-> !fresh)
    else $error("total taken on fresh tables");

endmodule

`default_nettype wire
